FILE: rtl/ase_pkg.sv
// Shared types, codes and constants for the ARM subset instruction executor.
package ase_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int REG_COUNT_DEF = 14;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [3:0]  SP_INDEX    = 4'd13;
  localparam logic [31:0] SP_RESET    = 32'h0000_2000;
  localparam logic [3:0]  PC_INDEX    = 4'd15;
  localparam logic [15:0] FLAGS_INDEX = 16'd16;

  localparam logic [1:0] OPC_WRITE = 2'd0;
  localparam logic [1:0] OPC_STEP  = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  localparam logic [1:0] CLS_XFER   = 2'd1;
  localparam logic [1:0] CLS_BRANCH = 2'd2;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;

  localparam logic [3:0] DP_AND = 4'd0;
  localparam logic [3:0] DP_EOR = 4'd1;
  localparam logic [3:0] DP_SUB = 4'd2;
  localparam logic [3:0] DP_RSB = 4'd3;
  localparam logic [3:0] DP_ADD = 4'd4;
  localparam logic [3:0] DP_TST = 4'd8;
  localparam logic [3:0] DP_TEQ = 4'd9;
  localparam logic [3:0] DP_CMP = 4'd10;
  localparam logic [3:0] DP_ORR = 4'd12;
  localparam logic [3:0] DP_MOV = 4'd13;

  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_GE = 4'd10;
  localparam logic [3:0] CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12;
  localparam logic [3:0] CC_LE = 4'd13;
  localparam logic [3:0] CC_AL = 4'd14;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] location;
    logic [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        cond_passed;
    logic        halted;
    logic        access_error;
    logic [15:0] next_pc;
  } rsp_t;

  typedef enum logic [1:0] {
    K_WRITE,
    K_STEP,
    K_READ,
    K_NOP
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [15:0] location;
    logic [31:0] word_in;
  } q_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDREG,
    S_FETCH,
    S_OPA,
    S_OPB,
    S_LOAD,
    S_DONE
  } back_state_t;

  function automatic logic [31:0] reg_init(input logic [3:0] idx);
    return (idx == SP_INDEX) ? SP_RESET : 32'd0;
  endfunction

endpackage

FILE: rtl/arm_subset_instruction_executor.sv
// Top level of the ARM subset instruction executor: front queue and execution back end.
//
//   channel  valid      stall      payload  transfer
//   request  req_valid  req_stall  req      valid high, stall low
//   result   rsp_valid  rsp_stall  rsp      valid high, stall low
//
// Back-end states per item: IDLE then DONE for a memory write, a no-op or a step while
// halted; RDREG for a register read, and FETCH for a step, which ends there when it halts,
// fails its condition or branches; data processing, multiply and store go on through OPA
// and OPB, and a load adds LOAD. The registered memory lanes and register file set these.
// After reset the memory is cleared one word row a cycle; while it clears,
// requests queue but are not executed.
// The two-entry queue takes requests while the back end or result waits, until it is full.
module arm_subset_instruction_executor import ase_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  ase_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  ase_back #(
    .MEM_BYTES (MEM_BYTES),
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/ase_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module ase_front import ase_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  output logic    q_valid,
  input  logic    q_pop,
  output q_item_t q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  item_kind_t         kind;
  logic               push;

  always_comb begin
    case (req.opcode)
      OPC_WRITE: kind = K_WRITE;
      OPC_STEP:  kind = K_STEP;
      OPC_READ:  kind = K_READ;
      default:   kind = K_NOP;
    endcase
  end

  assign req_stall = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != '0);
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: kind, location: req.location, word_in: req.word_in};
    end
  end

endmodule

FILE: rtl/ase_back.sv
// Back end: sequencer, register file, byte memory, shifter, multiplier and ALU.
module ase_back import ase_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_pop,
  input  q_item_t q_item,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  localparam int ROWS  = MEM_BYTES / 4;
  localparam int ROW_W = $clog2(ROWS);
  localparam int RI_W  = $clog2(REG_COUNT);
  localparam logic [3:0]  REG_LIM  = 4'(REG_COUNT);
  localparam logic [31:0] ADDR_MAX = 32'(MEM_BYTES - 4);

  back_state_t state, state_next;
  logic [ROW_W-1:0] clr_row, clr_row_next;
  logic [31:0] ins, ins_next;
  logic [15:0] at, at_next;
  logic [15:0] pc, pc_next;
  logic        halt, halt_next;
  logic [3:0]  flags, flags_next;
  logic [15:0] loc, loc_next;
  logic [31:0] res_value, res_value_next;
  logic        res_passed, res_passed_next;
  logic        res_err, res_err_next;
  logic [31:0] op2, op2_next;
  logic        sc, sc_next;
  logic [31:0] prod, prod_next;

  logic [16:0] mrd_addr;
  logic        mwr_en;
  logic [16:0] mwr_addr;
  logic [31:0] mwr_data;
  logic [3:0][7:0] lane_data;
  logic [3:0]  lane_oob;
  logic [3:0]  moob_q;
  logic [1:0]  mlo_q;
  logic [31:0] mword;
  logic        clearing;

  logic [31:0] rf [REG_COUNT];
  logic [REG_COUNT-1:0] rvalid;
  logic [3:0]  ra, rb, rf_wa;
  logic        rf_we;
  logic [31:0] rf_wd;
  logic [31:0] rfa_q, rfb_q;
  logic [31:0] pc8;

  logic        out_free;

  function automatic logic [32:0] shift_op(input logic [31:0] v, input logic [1:0] kind,
                                           input logic [7:0] amt, input logic cin);
    logic [63:0]        w;
    logic signed [63:0] sw;
    logic [4:0]         a5;
    logic [31:0]        r;
    logic               c;
    a5 = amt[4:0];
    r  = v;
    c  = cin;
    w  = '0;
    sw = '0;
    if (amt != 8'd0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 8'd32) begin
            w = {32'd0, v} << a5;
            r = w[31:0];
            c = w[32];
          end else begin
            r = '0;
            c = (amt == 8'd32) ? v[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (amt < 8'd32) begin
            w = {v, 32'd0} >> a5;
            r = w[63:32];
            c = w[31];
          end else begin
            r = '0;
            c = (amt == 8'd32) ? v[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (amt < 8'd32) begin
            sw = $signed({v, 32'd0}) >>> a5;
            r  = sw[63:32];
            c  = sw[31];
          end else begin
            r = {32{v[31]}};
            c = v[31];
          end
        end
        default: begin
          w = {v, v} >> a5;
          r = w[31:0];
          c = r[31];
        end
      endcase
    end
    return {c, r};
  endfunction

  function automatic logic cond_ok(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, v;
    n = f[3];
    z = f[2];
    v = f[0];
    case (cc)
      CC_EQ:   return z;
      CC_NE:   return !z;
      CC_GE:   return n == v;
      CC_LT:   return n != v;
      CC_GT:   return !z && (n == v);
      CC_LE:   return z || (n != v);
      CC_AL:   return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  assign clearing = (state == S_CLEAR);
  assign pc8      = {16'd0, at} + 32'd8;
  assign out_free = !rsp_valid || !rsp_stall;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0]  lane [ROWS];
    logic [7:0]  rdata;
    logic [1:0]  roff, woff;
    logic [16:0] raddr, waddr;
    assign roff = 2'(k) - mrd_addr[1:0];
    assign woff = 2'(k) - mwr_addr[1:0];
    assign raddr = mrd_addr + {15'd0, roff};
    assign waddr = mwr_addr + {15'd0, woff};
    assign lane_oob[k] = (raddr >= 17'(MEM_BYTES));
    always_ff @(posedge clk) begin
      if (clearing) begin
        lane[clr_row] <= '0;
      end else if (mwr_en) begin
        lane[waddr[ROW_W+1:2]] <= mwr_data[8*woff +: 8];
      end
      rdata <= lane[raddr[ROW_W+1:2]];
    end
    assign lane_data[k] = rdata;
  end

  always_comb begin
    logic [1:0] j;
    for (int i = 0; i < 4; i++) begin
      j = mlo_q + 2'(i);
      mword[8*i +: 8] = moob_q[j] ? 8'd0 : lane_data[j];
    end
  end

  always_ff @(posedge clk) begin
    moob_q <= lane_oob;
    mlo_q  <= mrd_addr[1:0];
    if (ra < REG_LIM) begin
      rfa_q <= rvalid[ra[RI_W-1:0]] ? rf[ra[RI_W-1:0]] : reg_init(ra);
    end else begin
      rfa_q <= (ra == PC_INDEX) ? pc8 : 32'd0;
    end
    if (rb < REG_LIM) begin
      rfb_q <= rvalid[rb[RI_W-1:0]] ? rf[rb[RI_W-1:0]] : reg_init(rb);
    end else begin
      rfb_q <= (rb == PC_INDEX) ? pc8 : 32'd0;
    end
    if (rf_we && rf_wa < REG_LIM) begin
      rf[rf_wa[RI_W-1:0]] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
    end else if (rf_we && rf_wa < REG_LIM) begin
      rvalid[rf_wa[RI_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      pc      <= '0;
      halt    <= 1'b0;
      flags   <= '0;
    end else begin
      state   <= state_next;
      clr_row <= clr_row_next;
      pc      <= pc_next;
      halt    <= halt_next;
      flags   <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    ins        <= ins_next;
    at         <= at_next;
    loc        <= loc_next;
    res_value  <= res_value_next;
    res_passed <= res_passed_next;
    res_err    <= res_err_next;
    op2        <= op2_next;
    sc         <= sc_next;
    prod       <= prod_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp <= '{read_value: res_value, cond_passed: res_passed, halted: halt,
               access_error: res_err, next_pc: pc};
    end
  end

  always_comb begin
    logic [32:0] sh;
    logic [63:0] rw;
    logic [31:0] immrot;
    logic        is_xfer, is_mul;
    logic [31:0] a, d, off, moved, addr, res;
    logic [32:0] sub_ab, sub_ba, add_ab;
    logic        ac, logical, keep, known, wb;

    state_next      = state;
    clr_row_next    = clr_row;
    ins_next        = ins;
    at_next         = at;
    pc_next         = pc;
    halt_next       = halt;
    flags_next      = flags;
    loc_next        = loc;
    res_value_next  = res_value;
    res_passed_next = res_passed;
    res_err_next    = res_err;
    op2_next        = op2;
    sc_next         = sc;
    prod_next       = prod;
    q_pop    = 1'b0;
    mrd_addr = '0;
    mwr_en   = 1'b0;
    mwr_addr = '0;
    mwr_data = '0;
    ra       = '0;
    rb       = '0;
    rf_we    = 1'b0;
    rf_wa    = '0;
    rf_wd    = '0;

    is_xfer = (ins[27:26] == CLS_XFER);
    is_mul  = (ins[7:4] == 4'd9) && (ins[27:22] == 6'd0);
    sh      = shift_op(rfa_q, ins[6:5], ins[4] ? rfb_q[7:0] : {3'd0, ins[11:7]}, flags[1]);
    rw      = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> {ins[11:8], 1'b0};
    immrot  = rw[31:0];
    a       = rfa_q;
    d       = rfb_q;
    off     = ins[25] ? op2 : {20'd0, ins[11:0]};
    moved   = ins[23] ? a + off : a - off;
    addr    = ins[24] ? moved : a;
    wb      = !ins[24] || ins[21];
    sub_ab  = {1'b0, a} - {1'b0, op2};
    sub_ba  = {1'b0, op2} - {1'b0, a};
    add_ab  = {1'b0, a} + {1'b0, op2};
    res     = '0;
    ac      = 1'b0;
    logical = 1'b1;
    keep    = 1'b1;
    known   = 1'b1;

    case (state)
      S_CLEAR: begin
        clr_row_next = clr_row + 1'b1;
        if (clr_row == ROW_W'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop           = 1'b1;
          loc_next        = q_item.location;
          res_value_next  = '0;
          res_passed_next = 1'b0;
          res_err_next    = 1'b0;
          state_next      = S_DONE;
          case (q_item.kind)
            K_WRITE: begin
              if ({16'd0, q_item.location} <= ADDR_MAX) begin
                mwr_en   = 1'b1;
                mwr_addr = {1'b0, q_item.location};
                mwr_data = q_item.word_in;
              end else begin
                res_err_next = 1'b1;
              end
            end
            K_READ: begin
              ra         = q_item.location[3:0];
              state_next = S_RDREG;
            end
            K_STEP: begin
              if (!halt) begin
                mrd_addr   = {1'b0, pc};
                at_next    = pc;
                state_next = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDREG: begin
        if (loc < {12'd0, REG_LIM}) begin
          res_value_next = rfa_q;
        end else if (loc == {12'd0, PC_INDEX}) begin
          res_value_next = {16'd0, pc};
        end else if (loc == FLAGS_INDEX) begin
          res_value_next = {28'd0, flags};
        end
        state_next = S_DONE;
      end
      S_FETCH: begin
        ins_next   = mword;
        state_next = S_DONE;
        if (mword == 32'd0) begin
          halt_next = 1'b1;
        end else begin
          res_value_next = mword;
          pc_next        = at + 16'd4;
          if (cond_ok(mword[31:28], flags)) begin
            res_passed_next = 1'b1;
            if (mword[27:26] == CLS_BRANCH) begin
              pc_next = at + 16'd8 + {mword[13:0], 2'b00};
            end else begin
              ra         = mword[3:0];
              rb         = mword[11:8];
              state_next = S_OPA;
            end
          end
        end
      end
      S_OPA: begin
        ra        = ins[19:16];
        rb        = ins[15:12];
        prod_next = rfa_q * rfb_q;
        if (!is_xfer && ins[25]) begin
          op2_next = immrot;
          sc_next  = (ins[11:8] != 4'd0) ? immrot[31] : flags[1];
        end else begin
          op2_next = sh[31:0];
          sc_next  = sh[32];
        end
        state_next = S_OPB;
      end
      S_OPB: begin
        state_next = S_DONE;
        if (is_xfer) begin
          if (wb) begin
            rf_we = 1'b1;
            rf_wa = ins[19:16];
            rf_wd = moved;
          end
          if (addr <= ADDR_MAX) begin
            if (ins[20]) begin
              mrd_addr   = {1'b0, addr[15:0]};
              state_next = S_LOAD;
            end else begin
              mwr_en   = 1'b1;
              mwr_addr = {1'b0, addr[15:0]};
              mwr_data = d;
            end
          end else begin
            res_err_next = 1'b1;
          end
        end else if (is_mul) begin
          res   = prod + (ins[21] ? d : 32'd0);
          rf_we = 1'b1;
          rf_wa = ins[19:16];
          rf_wd = res;
          if (ins[20]) begin
            flags_next[3] = res[31];
            flags_next[2] = (res == 32'd0);
          end
        end else begin
          case (ins[24:21])
            DP_AND: res = a & op2;
            DP_EOR: res = a ^ op2;
            DP_SUB: begin res = sub_ab[31:0]; ac = !sub_ab[32]; logical = 1'b0; end
            DP_RSB: begin res = sub_ba[31:0]; ac = !sub_ba[32]; logical = 1'b0; end
            DP_ADD: begin res = add_ab[31:0]; ac = add_ab[32]; logical = 1'b0; end
            DP_TST: begin res = a & op2; keep = 1'b0; end
            DP_TEQ: begin res = a ^ op2; keep = 1'b0; end
            DP_CMP: begin
              res = sub_ab[31:0]; ac = !sub_ab[32]; logical = 1'b0; keep = 1'b0;
            end
            DP_ORR: res = a | op2;
            DP_MOV: res = op2;
            default: known = 1'b0;
          endcase
          if (known) begin
            rf_we = keep;
            rf_wa = ins[15:12];
            rf_wd = res;
            if (ins[20]) begin
              flags_next[3] = res[31];
              flags_next[2] = (res == 32'd0);
              flags_next[1] = logical ? sc : ac;
            end
          end
        end
      end
      S_LOAD: begin
        rf_we      = 1'b1;
        rf_wa      = ins[15:12];
        rf_wd      = mword;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
